// ===== src/hpt_pkg.sv =====
// Package for the homogeneous point transform unit.
// Holds the widths, the item codes and the word types shared by the cell chain and the top level.
// Depends on nothing.
package hpt_pkg;

  localparam int COEF_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PT_W       = 32;
  localparam int Q_W        = 32;

  // Product, sum and quotient operand widths.
  localparam int PROD_W = COEF_WIDTH + PT_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int MAG_W  = SUM_W - FRAC_BITS;
  localparam int NUM_W  = MAG_W + FRAC_BITS;
  localparam int HI_W   = NUM_W - Q_W;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_t;

  // One divider lane: partial remainder, numerator bits still to shift in, quotient so far.
  typedef struct packed {
    logic [MAG_W-1:0] rem;
    logic [Q_W-1:0]   num;
    logic [Q_W-1:0]   quo;
    logic             neg;
    logic             ovf;
  } lane_t;

  // One word moving down the divider chain.
  typedef struct packed {
    lane_t            lx;
    lane_t            ly;
    lane_t            lz;
    logic [MAG_W-1:0] den;
    logic             w_zero;
  } div_word_t;

  // Coefficient as stored: low bits kept and sign-extended to the store width.
  function automatic logic signed [COEF_WIDTH-1:0] coef_of(input logic signed [PT_W-1:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    return e[COEF_WIDTH-1:0];
  endfunction

  // One in the coefficient format, wrapped to the store width.
  localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(64'd1 << FRAC_BITS);

endpackage

// ===== src/homogeneous_point_transform_unit.sv =====
// Top level of the homogeneous point transform unit.
// Depends on hpt_pkg and hpt_div_cell.

// The unit takes one word per cycle while in_stall is low and keeps a 4x4 column-major Q16.16
// matrix, reset to identity. A load word writes one coefficient at once and gives no result; a
// transform word gives one result word, x, y and z divided by w, through its registers in order
// (products, sums, magnitudes, divider setup, 32 divider cells, output register). Each stage
// advances when its successor has room, so a waiting result holds back only the stages behind it.
module homogeneous_point_transform_unit
  import hpt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [3:0]            in_coef_index,
  input  logic signed [PT_W-1:0] in_coef_value,
  input  logic signed [PT_W-1:0] in_point_x,
  input  logic signed [PT_W-1:0] in_point_y,
  input  logic signed [PT_W-1:0] in_point_z,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [Q_W-1:0] out_x,
  output logic signed [Q_W-1:0] out_y,
  output logic signed [Q_W-1:0] out_z,
  output logic                  out_w_zero,
  output logic                  out_saturated
);

  localparam int NCELL = Q_W;

  logic signed [COEF_WIDTH-1:0] mat_r [16];
  logic                         acc;

  logic                         s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, out_vld_r;
  logic                         s1_rdy, s2_rdy, s3_rdy, s4_rdy, o_rdy;
  logic signed [PROD_W-1:0]     prod_r [12];
  logic signed [COEF_WIDTH-1:0] trans_r [4];
  logic signed [MAG_W-1:0]      v_nxt [4];
  logic signed [MAG_W-1:0]      v_r [4];
  logic [MAG_W-1:0]             mag_r [4];
  logic [2:0]                   neg_r;
  logic                         wz_r;
  div_word_t                    s4_nxt, s4_r;

  logic                         vld_c [NCELL+1];
  logic                         rdy_c [NCELL+1];
  div_word_t                    word_c [NCELL+1];

  logic signed [Q_W-1:0]        ox_nxt, oy_nxt, oz_nxt;
  logic                         sat_nxt;
  logic signed [Q_W-1:0]        ox_r, oy_r, oz_r;
  logic                         wz_out_r, sat_r;

  assign acc = in_valid && !in_stall;

  // Ready chain from the output register back to the input.
  assign o_rdy     = !out_vld_r || !out_stall;
  assign rdy_c[NCELL] = o_rdy;
  assign s4_rdy    = !s4_vld_r || rdy_c[0];
  assign s3_rdy    = !s3_vld_r || s4_rdy;
  assign s2_rdy    = !s2_vld_r || s3_rdy;
  assign s1_rdy    = !s1_vld_r || s2_rdy;
  assign in_stall  = !s1_rdy;

  // Matrix store: identity after reset, one coefficient per load word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) begin
        mat_r[i] <= (i % 5 == 0) ? COEF_ONE : '0;
      end
    end else if (acc && in_op == OP_LOAD) begin
      mat_r[in_coef_index] <= coef_of(in_coef_value);
    end
  end

  // Stage 1: twelve products and the translation column.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_r <= acc && in_op == OP_XFORM;
    end
    if (acc && in_op == OP_XFORM) begin
      for (int r = 0; r < 4; r++) begin
        prod_r[r]     <= mat_r[r] * in_point_x;
        prod_r[4 + r] <= mat_r[4 + r] * in_point_y;
        prod_r[8 + r] <= mat_r[8 + r] * in_point_z;
        trans_r[r]    <= mat_r[12 + r];
      end
    end
  end

  // Stage 2: dot products, cut to the fraction width by an arithmetic shift.
  always_comb begin
    logic signed [SUM_W-1:0] s;
    for (int r = 0; r < 4; r++) begin
      s = SUM_W'(prod_r[r]) + SUM_W'(prod_r[4 + r]) + SUM_W'(prod_r[8 + r])
        + (SUM_W'(trans_r[r]) <<< FRAC_BITS);
      v_nxt[r] = s[SUM_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_r <= s1_vld_r;
    end
    if (s2_rdy && s1_vld_r) begin
      v_r <= v_nxt;
    end
  end

  // Stage 3: magnitudes, quotient signs and the zero-w check.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_vld_r <= s2_vld_r;
    end
    if (s3_rdy && s2_vld_r) begin
      for (int r = 0; r < 4; r++) begin
        mag_r[r] <= v_r[r][MAG_W-1] ? MAG_W'(-v_r[r]) : MAG_W'(v_r[r]);
      end
      for (int r = 0; r < 3; r++) begin
        neg_r[r] <= v_r[r][MAG_W-1] ^ v_r[3][MAG_W-1];
      end
      wz_r <= (v_r[3] == '0);
    end
  end

  // Stage 4: divider setup; a quotient of 2^32 or more is flagged before the chain.
  function automatic lane_t lane_init(input logic [MAG_W-1:0] mv, input logic [MAG_W-1:0] mw,
                                      input logic neg);
    logic [NUM_W-1:0] nx;
    logic [MAG_W-1:0] hi;
    lane_t            l;
    nx    = {mv, {FRAC_BITS{1'b0}}};
    hi    = MAG_W'(nx[NUM_W-1:Q_W]);
    l.ovf = (hi >= mw);
    l.rem = l.ovf ? '0 : hi;
    l.num = nx[Q_W-1:0];
    l.quo = '0;
    l.neg = neg;
    return l;
  endfunction

  always_comb begin
    s4_nxt.lx     = lane_init(mag_r[0], mag_r[3], neg_r[0]);
    s4_nxt.ly     = lane_init(mag_r[1], mag_r[3], neg_r[1]);
    s4_nxt.lz     = lane_init(mag_r[2], mag_r[3], neg_r[2]);
    s4_nxt.den    = mag_r[3];
    s4_nxt.w_zero = wz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (s4_rdy) begin
      s4_vld_r <= s3_vld_r;
    end
    if (s4_rdy && s3_vld_r) begin
      s4_r <= s4_nxt;
    end
  end

  // Divider chain: one quotient bit per cell, most significant first.
  assign vld_c[0]  = s4_vld_r;
  assign word_c[0] = s4_r;

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    hpt_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (vld_c[k]),
      .in_word  (word_c[k]),
      .rdy      (rdy_c[k]),
      .nxt_rdy  (rdy_c[k + 1]),
      .out_vld  (vld_c[k + 1]),
      .out_word (word_c[k + 1])
    );
  end

  // Output: apply signs, clip to the 32-bit range, force zeros when w is zero.
  function automatic logic signed [Q_W-1:0] lane_val(input lane_t l, output logic sat);
    logic big;
    big = l.ovf || (l.quo[Q_W-1] && (!l.neg || (l.quo[Q_W-2:0] != '0)));
    sat = big;
    if (big) begin
      return l.neg ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    end
    return l.neg ? -l.quo : l.quo;
  endfunction

  always_comb begin
    logic sx, sy, sz;
    ox_nxt  = lane_val(word_c[NCELL].lx, sx);
    oy_nxt  = lane_val(word_c[NCELL].ly, sy);
    oz_nxt  = lane_val(word_c[NCELL].lz, sz);
    sat_nxt = sx || sy || sz;
    if (word_c[NCELL].w_zero) begin
      ox_nxt  = '0;
      oy_nxt  = '0;
      oz_nxt  = '0;
      sat_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (o_rdy) begin
      out_vld_r <= vld_c[NCELL];
    end
    if (o_rdy && vld_c[NCELL]) begin
      ox_r     <= ox_nxt;
      oy_r     <= oy_nxt;
      oz_r     <= oz_nxt;
      wz_out_r <= word_c[NCELL].w_zero;
      sat_r    <= sat_nxt;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_x         = ox_r;
  assign out_y         = oy_r;
  assign out_z         = oz_r;
  assign out_w_zero    = wz_out_r;
  assign out_saturated = sat_r;

`ifndef SYNTHESIS
  // A zero-w result carries zeros and no clip flag.
  a_wzero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && wz_out_r) |-> (ox_r == '0 && oy_r == '0 && oz_r == '0 && !sat_r))
    else $error("zero-w result is not cleared");

  // A load word lands in the matrix store on the next cycle.
  a_load_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_op == OP_LOAD) |=> (mat_r[$past(in_coef_index)] == coef_of($past(in_coef_value))))
    else $error("coefficient load lost");

  // The input only stalls while the first stage holds a word.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_vld_r)
    else $error("input stalled with first stage empty");
`endif

endmodule

// ===== src/hpt_div_cell.sv =====
// One cell of the divider chain: retires one quotient bit for each of the three lanes.
// Depends on hpt_pkg.
module hpt_div_cell
  import hpt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  input  div_word_t in_word,
  output logic      rdy,
  input  logic      nxt_rdy,
  output logic      out_vld,
  output div_word_t out_word
);

  logic      vld_r;
  div_word_t word_r;
  div_word_t word_nxt;

  // Restoring step for one lane.
  function automatic lane_t step(input lane_t l, input logic [MAG_W-1:0] den);
    logic [MAG_W:0] r2;
    logic [MAG_W:0] diff;
    lane_t          o;
    r2   = {l.rem, l.num[Q_W-1]};
    diff = r2 - {1'b0, den};
    o    = l;
    o.num = {l.num[Q_W-2:0], 1'b0};
    if (r2 >= {1'b0, den}) begin
      o.rem = diff[MAG_W-1:0];
      o.quo = {l.quo[Q_W-2:0], 1'b1};
    end else begin
      o.rem = r2[MAG_W-1:0];
      o.quo = {l.quo[Q_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // Next word for this cell.
  always_comb begin
    word_nxt    = in_word;
    word_nxt.lx = step(in_word.lx, in_word.den);
    word_nxt.ly = step(in_word.ly, in_word.den);
    word_nxt.lz = step(in_word.lz, in_word.den);
  end

  assign rdy = !vld_r || nxt_rdy;

  // Stage register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (rdy) begin
      vld_r <= in_vld;
    end
    if (rdy && in_vld) begin
      word_r <= word_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_word = word_r;

endmodule
